@@ hw/rtl/srrip_adaptive_insertion_policy_core_defines.svh @@
// Assertion macros used by the replacement policy sequencer.
`ifndef SRRIP_ADAPTIVE_INSERTION_POLICY_CORE_DEFINES_SVH
`define SRRIP_ADAPTIVE_INSERTION_POLICY_CORE_DEFINES_SVH
`ifndef NO_ASSERTIONS
`define SRAP_ASSERT_HOLDS(lbl, clk, rst, cond, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (cond)) else $error(msg);
`define SRAP_ASSERT_NEXT(lbl, clk, rst, pre, post, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) else $error(msg);
`else
`define SRAP_ASSERT_HOLDS(lbl, clk, rst, cond, msg)
`define SRAP_ASSERT_NEXT(lbl, clk, rst, pre, post, msg)
`endif
`endif

@@ hw/rtl/srap_pkg.sv @@
// Types and constants of the SRRIP adaptive insertion policy.
package srap_pkg;
   localparam int LINE_W    = 58;
   localparam int STRIDE_W  = 32;
   localparam int CNT_W     = 6;
   localparam int LEVEL_W   = 3;
   localparam int CLASS_W   = 2;
   localparam int RRPV_W    = 2;
   localparam int PERIOD_W  = 13;
   localparam int PCT_W     = 7;
   localparam int LHS_W     = 20;
   localparam int RHS_W     = 21;
   localparam int CSR_IDX_W = 3;
   localparam int CSR_DAT_W = 13;
   localparam int REQ_DAT_W = 80;
   localparam int RSP_DAT_W = 16;

   localparam logic [RRPV_W-1:0]  RRPV_MAX    = 2'd3;
   localparam logic [RRPV_W-1:0]  RRPV_NEAR   = 2'd0;
   localparam logic [RRPV_W-1:0]  RRPV_MID    = 2'd1;
   localparam logic [LEVEL_W-1:0] LEVEL_MAX   = 3'd7;
   localparam logic [LEVEL_W-1:0] LEVEL_RESET = 3'd4;
   localparam logic [LEVEL_W-1:0] LEVEL_LOW   = 3'd2;
   localparam logic [LHS_W-1:0]   MISS_SCALE  = 20'd100;

   localparam logic [CLASS_W-1:0] CLASS_STREAM   = 2'd0;
   localparam logic [CLASS_W-1:0] CLASS_SPATIAL  = 2'd1;
   localparam logic [CLASS_W-1:0] CLASS_TEMPORAL = 2'd2;

   localparam logic [CSR_IDX_W-1:0] CSR_WINDOW_LENGTH  = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_SPATIAL_MIN    = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_STREAM_MIN     = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_TEMPORAL_MIN   = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_GLOBAL_PERIOD  = 3'd4;
   localparam logic [CSR_IDX_W-1:0] CSR_GLOBAL_PERCENT = 3'd5;

   typedef struct packed {
      logic [CNT_W-1:0]    window_length;
      logic [3:0]          spatial_repeat_min;
      logic [CNT_W-1:0]    stream_miss_min;
      logic [CNT_W-1:0]    temporal_hit_min;
      logic [PERIOD_W-1:0] global_period;
      logic [PCT_W-1:0]    global_miss_percent;
   } cfg_type;

   typedef enum logic [4:0] {
      ST_CLR, ST_IDLE, ST_MOD, ST_RD, ST_LD, ST_VIC, ST_UPD, ST_RDI, ST_LDI,
      ST_CMP, ST_EVAL, ST_GLB, ST_GMUL, ST_GCMP, ST_POS, ST_WR, ST_DONE
   } state_type;
endpackage

@@ hw/rtl/srap_ram.sv @@
// Single-port-write, registered-read memory.
module srap_ram #(
   parameter int DEPTH = 2048,
   parameter int WIDTH = 8
) (
   input  logic                                  clock,
   input  logic                                  wr_en,
   input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  logic [WIDTH-1:0]                      wr_data,
   input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic [WIDTH-1:0]                      rd_data
);
   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;
endmodule

@@ hw/rtl/srap_seq.sv @@
// Sequencer with shared stride compare unit, set row handling and global predictor.
`include "srrip_adaptive_insertion_policy_core_defines.svh"
module srap_seq #(
   parameter int NUM_SETS     = 2048,
   parameter int NUM_WAYS     = 16,
   parameter int STRIDE_DEPTH = 8
) (
   input  logic                          clock,
   input  logic                          reset,
   input  srap_pkg::cfg_type             cfg,
   input  logic                          req_tvalid,
   output logic                          req_tready,
   input  logic [srap_pkg::REQ_DAT_W-1:0] req_tdata,
   input  logic                          req_tuser,
   output logic                          rsp_tvalid,
   input  logic                          rsp_tready,
   output logic [srap_pkg::RSP_DAT_W-1:0] rsp_tdata
);
   localparam int SW   = NUM_SETS > 1 ? $clog2(NUM_SETS) : 1;
   localparam int DW   = STRIDE_DEPTH > 1 ? $clog2(STRIDE_DEPTH) : 1;
   localparam int FW   = $clog2(STRIDE_DEPTH + 1);
   localparam int WW   = $clog2(NUM_WAYS);
   localparam int SDEP = NUM_SETS * STRIDE_DEPTH;
   localparam int SAW  = SDEP > 1 ? $clog2(SDEP) : 1;
   localparam int LW   = srap_pkg::LINE_W;
   localparam int CW   = srap_pkg::CNT_W;
   localparam int VLD_LO  = 2 * NUM_WAYS;
   localparam int PREV_LO = 3 * NUM_WAYS;
   localparam int FILL_LO = PREV_LO + LW;
   localparam int HEAD_LO = FILL_LO + FW;
   localparam int HIT_LO  = HEAD_LO + DW;
   localparam int MIS_LO  = HIT_LO + CW;
   localparam int REU_LO  = MIS_LO + CW;
   localparam int CLS_LO  = REU_LO + srap_pkg::LEVEL_W;
   localparam int RW      = CLS_LO + srap_pkg::CLASS_W;

   srap_pkg::state_type state_ff, state_in;
   logic [SW-1:0]  clr_ff, clr_in;
   logic           op_ff, op_in, hitreq_ff, hitreq_in;
   logic [10:0]    s_ff, s_in;
   logic [3:0]     way_ff, way_in;
   logic [LW-1:0]  line_ff, line_in;
   logic [NUM_WAYS-1:0][1:0] rr_ff, rr_in;
   logic [NUM_WAYS-1:0] vld_ff, vld_in;
   logic [LW-1:0]  prev_ff, prev_in;
   logic [FW-1:0]  fill_ff, fill_in, best_ff, best_in, cnt_ff, cnt_in;
   logic [DW-1:0]  head_ff, head_in, i_ff, i_in, j_ff, j_in;
   logic [CW-1:0]  hits_ff, hits_in, mis_ff, mis_in;
   logic [2:0]     reuse_ff, reuse_in;
   logic [1:0]     cls_ff, cls_in;
   logic [31:0]    ref_ff, ref_in;
   logic [12:0]    acc_ff, acc_in, pmis_ff, pmis_in;
   logic           retain_ff, retain_in;
   logic [srap_pkg::LHS_W-1:0] lhs_ff, lhs_in;
   logic [srap_pkg::RHS_W-1:0] rhs_ff, rhs_in;
   logic [3:0]     res_way_ff, res_way_in;
   logic [1:0]     res_pos_ff, res_pos_in;
   logic           rsp_valid_ff, rsp_valid_in;
   logic [srap_pkg::RSP_DAT_W-1:0] rsp_data_ff, rsp_data_in;

   logic [SW-1:0]  set_addr;
   logic           set_we;
   logic [SW-1:0]  set_wr_addr;
   logic [RW-1:0]  set_wr_data, set_rd_data, row_pack, row_reset;
   logic           str_we;
   logic [DW-1:0]  str_rd_slot;
   logic [SAW-1:0] str_wr_addr, str_rd_addr;
   logic [31:0]    str_rd_data, stride_d;

   logic           any_inv, any3, any2, any1;
   logic [1:0]     top, add;
   logic [WW-1:0]  inv_way, max_way;
   logic [NUM_WAYS-1:0][1:0] aged;
   logic           spatial, streaming, temporal, last_j, last_i;
   logic [1:0]     pos;

   assign set_addr  = SW'(s_ff);
   assign row_pack  = {cls_ff, reuse_ff, mis_ff, hits_ff, head_ff, fill_ff, prev_ff,
                       vld_ff, rr_ff};
   assign row_reset = {srap_pkg::CLASS_SPATIAL, srap_pkg::LEVEL_RESET, {CW{1'b0}},
                       {CW{1'b0}}, {DW{1'b0}}, {FW{1'b0}}, {LW{1'b0}},
                       {NUM_WAYS{1'b0}}, {(2 * NUM_WAYS){1'b1}}};
   assign set_wr_addr = (state_ff == srap_pkg::ST_CLR) ? clr_ff : set_addr;
   assign set_wr_data = (state_ff == srap_pkg::ST_CLR) ? row_reset : row_pack;
   assign set_we      = (state_ff == srap_pkg::ST_CLR) || (state_ff == srap_pkg::ST_WR);

   assign stride_d    = line_ff[31:0] - prev_ff[31:0];
   assign str_we      = (state_ff == srap_pkg::ST_UPD) && (prev_ff != '0) && (stride_d != '0);
   assign str_wr_addr = SAW'(int'(set_addr) * STRIDE_DEPTH + int'(head_ff));
   assign str_rd_addr = SAW'(int'(set_addr) * STRIDE_DEPTH + int'(str_rd_slot));

   always_comb begin
      case (state_ff)
         srap_pkg::ST_RDI: str_rd_slot = i_ff;
         srap_pkg::ST_LDI: str_rd_slot = '0;
         default:          str_rd_slot = j_ff + DW'(1);
      endcase
   end

   srap_ram #(.DEPTH(NUM_SETS), .WIDTH(RW)) u_set_ram (
      .clock   (clock),
      .wr_en   (set_we),
      .wr_addr (set_wr_addr),
      .wr_data (set_wr_data),
      .rd_addr (set_addr),
      .rd_data (set_rd_data)
   );

   srap_ram #(.DEPTH(SDEP), .WIDTH(srap_pkg::STRIDE_W)) u_stride_ram (
      .clock   (clock),
      .wr_en   (str_we),
      .wr_addr (str_wr_addr),
      .wr_data (stride_d),
      .rd_addr (str_rd_addr),
      .rd_data (str_rd_data)
   );

   always_comb begin
      any_inv = ~&vld_ff;
      inv_way = '0;
      max_way = '0;
      any3 = 1'b0;
      any2 = 1'b0;
      any1 = 1'b0;
      for (int w = NUM_WAYS - 1; w >= 0; w--) begin
         if (!vld_ff[w]) inv_way = WW'(w);
         any3 = any3 | (rr_ff[w] == 2'd3);
         any2 = any2 | (rr_ff[w] == 2'd2);
         any1 = any1 | (rr_ff[w] == 2'd1);
      end
      top = any3 ? 2'd3 : any2 ? 2'd2 : any1 ? 2'd1 : 2'd0;
      add = srap_pkg::RRPV_MAX - top;
      for (int w = NUM_WAYS - 1; w >= 0; w--) begin
         aged[w] = rr_ff[w] + add;
         if (aged[w] == srap_pkg::RRPV_MAX) max_way = WW'(w);
      end
   end

   assign spatial   = 8'(best_ff) >= 8'(cfg.spatial_repeat_min);
   assign streaming = !spatial && (mis_ff > cfg.stream_miss_min);
   assign temporal  = !spatial && (hits_ff > cfg.temporal_hit_min);
   assign last_j    = FW'(j_ff) == FW'(fill_ff - FW'(1));
   assign last_i    = FW'(i_ff) == FW'(fill_ff - FW'(1));

   always_comb begin
      if (hitreq_ff) pos = srap_pkg::RRPV_NEAR;
      else if (!retain_ff) pos = srap_pkg::RRPV_MAX;
      else if (cls_ff == srap_pkg::CLASS_STREAM) pos = srap_pkg::RRPV_MAX;
      else if (cls_ff == srap_pkg::CLASS_SPATIAL) pos = srap_pkg::RRPV_MID;
      else pos = srap_pkg::RRPV_NEAR;
   end

   always_comb begin
      state_in = state_ff;
      clr_in = clr_ff;
      op_in = op_ff;
      hitreq_in = hitreq_ff;
      s_in = s_ff;
      way_in = way_ff;
      line_in = line_ff;
      rr_in = rr_ff;
      vld_in = vld_ff;
      prev_in = prev_ff;
      fill_in = fill_ff;
      best_in = best_ff;
      cnt_in = cnt_ff;
      head_in = head_ff;
      i_in = i_ff;
      j_in = j_ff;
      hits_in = hits_ff;
      mis_in = mis_ff;
      reuse_in = reuse_ff;
      cls_in = cls_ff;
      ref_in = ref_ff;
      acc_in = acc_ff;
      pmis_in = pmis_ff;
      retain_in = retain_ff;
      lhs_in = lhs_ff;
      rhs_in = rhs_ff;
      res_way_in = res_way_ff;
      res_pos_in = res_pos_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      rsp_data_in = rsp_data_ff;
      req_tready = 1'b0;
      case (state_ff)
         srap_pkg::ST_CLR: begin
            clr_in = clr_ff + SW'(1);
            if (clr_ff == SW'(NUM_SETS - 1)) state_in = srap_pkg::ST_IDLE;
         end
         srap_pkg::ST_IDLE: begin
            req_tready = 1'b1;
            if (req_tvalid) begin
               op_in = req_tuser;
               s_in = req_tdata[10:0];
               way_in = req_tdata[14:11];
               line_in = req_tdata[78:21];
               hitreq_in = req_tdata[79];
               res_way_in = req_tdata[14:11];
               state_in = srap_pkg::ST_MOD;
            end
         end
         srap_pkg::ST_MOD: begin
            if (17'(s_ff) >= 17'(NUM_SETS)) s_in = s_ff - 11'(NUM_SETS);
            else state_in = srap_pkg::ST_RD;
         end
         srap_pkg::ST_RD: state_in = srap_pkg::ST_LD;
         srap_pkg::ST_LD: begin
            rr_in = set_rd_data[VLD_LO-1:0];
            vld_in = set_rd_data[PREV_LO-1:VLD_LO];
            prev_in = set_rd_data[FILL_LO-1:PREV_LO];
            fill_in = set_rd_data[HEAD_LO-1:FILL_LO];
            head_in = set_rd_data[HIT_LO-1:HEAD_LO];
            hits_in = set_rd_data[MIS_LO-1:HIT_LO];
            mis_in = set_rd_data[REU_LO-1:MIS_LO];
            reuse_in = set_rd_data[CLS_LO-1:REU_LO];
            cls_in = set_rd_data[RW-1:CLS_LO];
            state_in = op_ff ? srap_pkg::ST_UPD : srap_pkg::ST_VIC;
         end
         srap_pkg::ST_VIC: begin
            res_pos_in = srap_pkg::RRPV_MAX;
            if (any_inv) begin
               res_way_in = 4'(inv_way);
            end else begin
               rr_in = aged;
               res_way_in = 4'(max_way);
            end
            state_in = srap_pkg::ST_WR;
         end
         srap_pkg::ST_UPD: begin
            if (str_we) begin
               head_in = (head_ff == DW'(STRIDE_DEPTH - 1)) ? '0 : head_ff + DW'(1);
               if (fill_ff < FW'(STRIDE_DEPTH)) fill_in = fill_ff + FW'(1);
            end
            prev_in = line_ff;
            if (hitreq_ff) hits_in = hits_ff + CW'(1);
            else mis_in = mis_ff + CW'(1);
            i_in = '0;
            best_in = '0;
            if (7'(hits_in) + 7'(mis_in) >= 7'(cfg.window_length)) begin
               state_in = (fill_in == '0) ? srap_pkg::ST_EVAL : srap_pkg::ST_RDI;
            end else begin
               state_in = srap_pkg::ST_GLB;
            end
         end
         srap_pkg::ST_RDI: state_in = srap_pkg::ST_LDI;
         srap_pkg::ST_LDI: begin
            ref_in = str_rd_data;
            j_in = '0;
            cnt_in = '0;
            state_in = srap_pkg::ST_CMP;
         end
         srap_pkg::ST_CMP: begin
            cnt_in = cnt_ff + FW'(str_rd_data == ref_ff);
            if (last_j) begin
               if (cnt_in > best_ff) best_in = cnt_in;
               i_in = i_ff + DW'(1);
               state_in = last_i ? srap_pkg::ST_EVAL : srap_pkg::ST_RDI;
            end else begin
               j_in = j_ff + DW'(1);
            end
         end
         srap_pkg::ST_EVAL: begin
            if (streaming) begin
               if (reuse_ff != '0) reuse_in = reuse_ff - 3'd1;
            end else if (spatial || temporal) begin
               if (reuse_ff < srap_pkg::LEVEL_MAX) reuse_in = reuse_ff + 3'd1;
            end
            if (reuse_in <= srap_pkg::LEVEL_LOW) cls_in = srap_pkg::CLASS_STREAM;
            else if (spatial) cls_in = srap_pkg::CLASS_SPATIAL;
            else cls_in = srap_pkg::CLASS_TEMPORAL;
            hits_in = '0;
            mis_in = '0;
            fill_in = '0;
            head_in = '0;
            state_in = srap_pkg::ST_GLB;
         end
         srap_pkg::ST_GLB: begin
            acc_in = acc_ff + 13'd1;
            if (!hitreq_ff) pmis_in = pmis_ff + 13'd1;
            state_in = srap_pkg::ST_GMUL;
         end
         srap_pkg::ST_GMUL: begin
            lhs_in = srap_pkg::LHS_W'(pmis_ff) * srap_pkg::MISS_SCALE;
            rhs_in = srap_pkg::RHS_W'(8'(cfg.global_miss_percent) + 8'd1)
                     * srap_pkg::RHS_W'(cfg.global_period);
            state_in = (acc_ff >= cfg.global_period) ? srap_pkg::ST_GCMP : srap_pkg::ST_POS;
         end
         srap_pkg::ST_GCMP: begin
            retain_in = !(srap_pkg::RHS_W'(lhs_ff) >= rhs_ff);
            acc_in = '0;
            pmis_in = '0;
            state_in = srap_pkg::ST_POS;
         end
         srap_pkg::ST_POS: begin
            res_pos_in = pos;
            if (6'(way_ff) < 6'(NUM_WAYS)) begin
               rr_in[WW'(way_ff)] = pos;
               vld_in[WW'(way_ff)] = 1'b1;
            end
            state_in = srap_pkg::ST_WR;
         end
         srap_pkg::ST_WR: state_in = srap_pkg::ST_DONE;
         srap_pkg::ST_DONE: begin
            if (!rsp_valid_ff || rsp_tready) begin
               rsp_valid_in = 1'b1;
               rsp_data_in = {7'd0, retain_ff, cls_ff, res_pos_ff, res_way_ff};
               state_in = srap_pkg::ST_IDLE;
            end
         end
         default: state_in = srap_pkg::ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= srap_pkg::ST_CLR;
         clr_ff <= '0;
         acc_ff <= '0;
         pmis_ff <= '0;
         retain_ff <= 1'b1;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         clr_ff <= clr_in;
         acc_ff <= acc_in;
         pmis_ff <= pmis_in;
         retain_ff <= retain_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      op_ff <= op_in;
      hitreq_ff <= hitreq_in;
      s_ff <= s_in;
      way_ff <= way_in;
      line_ff <= line_in;
      rr_ff <= rr_in;
      vld_ff <= vld_in;
      prev_ff <= prev_in;
      fill_ff <= fill_in;
      best_ff <= best_in;
      cnt_ff <= cnt_in;
      head_ff <= head_in;
      i_ff <= i_in;
      j_ff <= j_in;
      hits_ff <= hits_in;
      mis_ff <= mis_in;
      reuse_ff <= reuse_in;
      cls_ff <= cls_in;
      ref_ff <= ref_in;
      lhs_ff <= lhs_in;
      rhs_ff <= rhs_in;
      res_way_ff <= res_way_in;
      res_pos_ff <= res_pos_in;
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

   `SRAP_ASSERT_HOLDS(a_cmp_bounds, clock, reset, (state_ff != srap_pkg::ST_CMP) || (FW'(j_ff) < fill_ff && FW'(i_ff) < fill_ff), "stride compare index beyond fill")
   `SRAP_ASSERT_NEXT(a_accept, clock, reset, req_tvalid && req_tready, state_ff == srap_pkg::ST_MOD, "accepted item did not start")
   `SRAP_ASSERT_NEXT(a_done, clock, reset, state_ff == srap_pkg::ST_DONE && (!rsp_valid_ff || rsp_tready), rsp_valid_ff && state_ff == srap_pkg::ST_IDLE, "result not posted")
endmodule

@@ hw/rtl/srrip_adaptive_insertion_policy_core.sv @@
// Top level: configuration registers and the policy sequencer.
// Victim request: MOD, RD, LD, VIC, WR, DONE after accept; MOD takes one step for each
// NUM_SETS folded off a set_index at or above NUM_SETS. Requests are taken only in IDLE.
// Update: MOD, RD, LD, UPD, GLB, GMUL, POS, WR, DONE; GCMP also at a global period end; a
// window end adds RDI, LDI and CMP over each pair of n stored strides, then EVAL, via
// the single 32-bit stride comparator and its memory read port. The result register
// takes the next item while it waits. Synchronous reset, then a not-ready set-memory clear.
module srrip_adaptive_insertion_policy_core #(
   parameter int NUM_SETS     = 2048,
   parameter int NUM_WAYS     = 16,
   parameter int STRIDE_DEPTH = 8
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_tvalid,
   output logic                           req_tready,
   input  logic [srap_pkg::REQ_DAT_W-1:0] req_tdata,  // set_index, way_index, phys_addr, was_hit
   input  logic                           req_tuser,  // op
   output logic                           rsp_tvalid,
   input  logic                           rsp_tready,
   output logic [srap_pkg::RSP_DAT_W-1:0] rsp_tdata,  // chosen_way, written_position,
                                                      // set_class_out, global_retain_out
   input  logic                           csr_we,
   input  logic [srap_pkg::CSR_IDX_W-1:0] csr_index,
   input  logic [srap_pkg::CSR_DAT_W-1:0] csr_wdata
);
   srap_pkg::cfg_type cfg_ff, cfg_in;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_we) begin
         case (csr_index)
            srap_pkg::CSR_WINDOW_LENGTH:  cfg_in.window_length = csr_wdata[5:0];
            srap_pkg::CSR_SPATIAL_MIN:    cfg_in.spatial_repeat_min = csr_wdata[3:0];
            srap_pkg::CSR_STREAM_MIN:     cfg_in.stream_miss_min = csr_wdata[5:0];
            srap_pkg::CSR_TEMPORAL_MIN:   cfg_in.temporal_hit_min = csr_wdata[5:0];
            srap_pkg::CSR_GLOBAL_PERIOD:  cfg_in.global_period = csr_wdata[12:0];
            srap_pkg::CSR_GLOBAL_PERCENT: cfg_in.global_miss_percent = csr_wdata[6:0];
            default: cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.window_length <= 6'd32;
         cfg_ff.spatial_repeat_min <= 4'd6;
         cfg_ff.stream_miss_min <= 6'd24;
         cfg_ff.temporal_hit_min <= 6'd16;
         cfg_ff.global_period <= 13'd4096;
         cfg_ff.global_miss_percent <= 7'd60;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   srap_seq #(
      .NUM_SETS     (NUM_SETS),
      .NUM_WAYS     (NUM_WAYS),
      .STRIDE_DEPTH (STRIDE_DEPTH)
   ) u_seq (
      .clock      (clock),
      .reset      (reset),
      .cfg        (cfg_ff),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );
endmodule
